### rtl/via_tir_pkg.sv
// ----------------------------------------------------------------------------
// via_tir_pkg
// shared codes for the interface adapter: commands, register map, flag bits
// ----------------------------------------------------------------------------
package via_tir_pkg;

	// commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// register map
	localparam logic [3:0] REG_ORB   = 4'd0;
	localparam logic [3:0] REG_ORA   = 4'd1;
	localparam logic [3:0] REG_DDRB  = 4'd2;
	localparam logic [3:0] REG_DDRA  = 4'd3;
	localparam logic [3:0] REG_T1CL  = 4'd4;
	localparam logic [3:0] REG_T1CH  = 4'd5;
	localparam logic [3:0] REG_T1LL  = 4'd6;
	localparam logic [3:0] REG_T1LH  = 4'd7;
	localparam logic [3:0] REG_T2CL  = 4'd8;
	localparam logic [3:0] REG_T2CH  = 4'd9;
	localparam logic [3:0] REG_SR    = 4'd10;
	localparam logic [3:0] REG_ACR   = 4'd11;
	localparam logic [3:0] REG_PCR   = 4'd12;
	localparam logic [3:0] REG_IFR   = 4'd13;
	localparam logic [3:0] REG_IER   = 4'd14;
	localparam logic [3:0] REG_ORA_NH = 4'd15;

	// flag bit positions inside the 7-bit flag and enable words
	localparam int FLAG_T1 = 6;
	localparam int FLAG_T2 = 5;

	// aux control bits
	localparam int ACR_T1_FREE_RUN = 6;
	localparam int ACR_T2_PULSE    = 5;

	// enable register write: set when this data bit is 1, else clear
	localparam int IER_SET_BIT = 7;

	typedef logic [6:0] irq_vec_t;

endpackage

### rtl/via_timer_interrupt_registers.sv
// ----------------------------------------------------------------------------
// via_timer_interrupt_registers
// versatile interface adapter: ports, two timers and interrupt flags
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid / in_ready) carries one bus item: a register
//    read, a register write or a tick of some number of clocks, with the
//    current pin levels of ports A and B
//  - output channel (out_valid / out_ready) returns exactly one result item
//    per input item: the read byte (zero unless a read), the enabled pending
//    flags and the masked port outputs and directions after the command
//  - an accepted item lands in an input register, the state update and the
//    result are formed in one pass of short logic (one 16-bit compare and
//    subtract per timer) and captured in the result register
//  - out_valid rises once the item has moved from the input register into
//    the result register; one item per cycle is sustained as long as
//    out_ready stays high
//  - when the receiver stalls the result register holds, the input register
//    still takes one more item, then in_ready drops until the result leaves
//  - arst_n clears all adapter registers, the timers and the valid bits;
//    no item is in flight after reset
// ----------------------------------------------------------------------------
module via_timer_interrupt_registers
	import via_tir_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [3:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic [15:0] clocks,
	input  logic [7:0]  port_a_in,
	input  logic [7:0]  port_b_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [6:0]  irq_bits,
	output logic [7:0]  port_a_out,
	output logic [7:0]  port_b_out,
	output logic [7:0]  dir_a,
	output logic [7:0]  dir_b
);

	// ---------------- input register ----------------
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [3:0]  addr_s1;
	logic [7:0]  data_s1;
	logic [15:0] clocks_s1;
	logic [7:0]  pins_a_s1;
	logic [7:0]  pins_b_s1;

	// ---------------- result register ----------------
	logic        valid_s2;
	logic [7:0]  read_data_s2;
	irq_vec_t    irq_bits_s2;
	logic [7:0]  port_a_out_s2;
	logic [7:0]  port_b_out_s2;
	logic [7:0]  dir_a_s2;
	logic [7:0]  dir_b_s2;

	// ---------------- adapter state ----------------
	// flag bit 7 is always the or of the enabled flags, so only 6..0 are kept
	logic [7:0]  acr_q;
	logic [7:0]  pcr_q;
	irq_vec_t    flags_q;
	irq_vec_t    enable_q;
	logic [7:0]  sr_q;
	logic [7:0]  latch_a_q;
	logic [7:0]  latch_b_q;
	logic [7:0]  ddr_a_q;
	logic [7:0]  ddr_b_q;
	logic [15:0] t1_count_q;
	logic [15:0] t1_latch_q;
	logic [15:0] t2_count_q;
	logic [7:0]  t2_low_q;

	// next-state values
	logic [7:0]  acr_d;
	logic [7:0]  pcr_d;
	irq_vec_t    flags_d;
	irq_vec_t    enable_d;
	logic [7:0]  sr_d;
	logic [7:0]  latch_a_d;
	logic [7:0]  latch_b_d;
	logic [7:0]  ddr_a_d;
	logic [7:0]  ddr_b_d;
	logic [15:0] t1_count_d;
	logic [15:0] t1_latch_d;
	logic [15:0] t2_count_d;
	logic [7:0]  t2_low_d;
	logic [7:0]  rd_d;
	irq_vec_t    pending_d;

	logic        adv_s1;
	logic        pending_q;

	// the input register moves on when the result register is free or leaving
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	assign pending_q = |(enable_q & flags_q);

	// ---------------- command logic ----------------
	always_comb begin
		acr_d      = acr_q;
		pcr_d      = pcr_q;
		flags_d    = flags_q;
		enable_d   = enable_q;
		sr_d       = sr_q;
		latch_a_d  = latch_a_q;
		latch_b_d  = latch_b_q;
		ddr_a_d    = ddr_a_q;
		ddr_b_d    = ddr_b_q;
		t1_count_d = t1_count_q;
		t1_latch_d = t1_latch_q;
		t2_count_d = t2_count_q;
		t2_low_d   = t2_low_q;
		rd_d       = 8'd0;

		unique case (cmd_s1)
			CMD_READ: begin
				unique case (addr_s1)
					REG_ORB:  rd_d = (pins_b_s1 & ~ddr_b_q) | (latch_b_q & ddr_b_q);
					REG_ORA:  rd_d = (pins_a_s1 & ~ddr_a_q) | (latch_a_q & ddr_a_q);
					REG_DDRB: rd_d = ddr_b_q;
					REG_DDRA: rd_d = ddr_a_q;
					REG_T1CL: begin
						// reading the low count acknowledges timer 1
						flags_d[FLAG_T1] = 1'b0;
						rd_d = t1_count_q[7:0];
					end
					REG_T1CH: rd_d = t1_count_q[15:8];
					REG_T1LL: rd_d = t1_latch_q[7:0];
					REG_T1LH: rd_d = t1_latch_q[15:8];
					REG_T2CL: begin
						flags_d[FLAG_T2] = 1'b0;
						rd_d = t2_count_q[7:0];
					end
					REG_T2CH: rd_d = t2_count_q[15:8];
					REG_SR:   rd_d = sr_q;
					REG_ACR:  rd_d = acr_q;
					REG_PCR:  rd_d = pcr_q;
					REG_IFR:  rd_d = {pending_q, flags_q};
					REG_IER:  rd_d = {1'b0, enable_q};
					REG_ORA_NH: rd_d = pins_a_s1;
				endcase
			end
			CMD_WRITE: begin
				unique case (addr_s1)
					REG_ORB:  latch_b_d = data_s1;
					REG_ORA:  latch_a_d = data_s1;
					REG_DDRB: ddr_b_d   = data_s1;
					REG_DDRA: ddr_a_d   = data_s1;
					REG_T1CL: t1_latch_d[7:0] = data_s1;
					REG_T1CH: begin
						// high byte loads the counter from the whole latch
						t1_latch_d[15:8] = data_s1;
						t1_count_d       = {data_s1, t1_latch_q[7:0]};
						flags_d[FLAG_T1] = 1'b0;
					end
					REG_T1LL: t1_latch_d[7:0]  = data_s1;
					REG_T1LH: t1_latch_d[15:8] = data_s1;
					REG_T2CL: t2_low_d = data_s1;
					REG_T2CH: begin
						t2_count_d       = {data_s1, t2_low_q};
						flags_d[FLAG_T2] = 1'b0;
					end
					REG_SR:   sr_d  = data_s1;
					REG_ACR:  acr_d = data_s1;
					REG_PCR:  pcr_d = data_s1;
					REG_IFR:  flags_d = flags_q & ~data_s1[6:0];
					REG_IER: begin
						if (data_s1[IER_SET_BIT]) begin
							enable_d = enable_q | data_s1[6:0];
						end else begin
							enable_d = enable_q & ~data_s1[6:0];
						end
					end
					REG_ORA_NH: latch_a_d = data_s1;
				endcase
			end
			CMD_TICK: begin
				// timer 1: free run reloads latch plus one, else stops at zero
				if (t1_count_q != 16'd0) begin
					if (clocks_s1 >= t1_count_q) begin
						flags_d[FLAG_T1] = 1'b1;
						t1_count_d = acr_q[ACR_T1_FREE_RUN] ? t1_latch_q + 16'd1 : 16'd0;
					end else begin
						t1_count_d = t1_count_q - clocks_s1;
					end
				end
				// timer 2: one-shot, frozen in pulse count mode
				if (t2_count_q != 16'd0 && !acr_q[ACR_T2_PULSE]) begin
					if (clocks_s1 >= t2_count_q) begin
						flags_d[FLAG_T2] = 1'b1;
						t2_count_d = 16'd0;
					end else begin
						t2_count_d = t2_count_q - clocks_s1;
					end
				end
			end
			default: begin
				// unused command leaves everything alone
			end
		endcase

		pending_d = enable_d & flags_d;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input payload, captured on acceptance
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= command;
			addr_s1   <= reg_addr;
			data_s1   <= write_data;
			clocks_s1 <= clocks;
			pins_a_s1 <= port_a_in;
			pins_b_s1 <= port_b_in;
		end
	end

	// result payload, formed from the state after the command
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_s2  <= rd_d;
			irq_bits_s2   <= pending_d;
			port_a_out_s2 <= latch_a_d & ddr_a_d;
			port_b_out_s2 <= latch_b_d & ddr_b_d;
			dir_a_s2      <= ddr_a_d;
			dir_b_s2      <= ddr_b_d;
		end
	end

	// adapter state changes only when an item completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acr_q      <= 8'd0;
			pcr_q      <= 8'd0;
			flags_q    <= '0;
			enable_q   <= '0;
			sr_q       <= 8'd0;
			latch_a_q  <= 8'd0;
			latch_b_q  <= 8'd0;
			ddr_a_q    <= 8'd0;
			ddr_b_q    <= 8'd0;
			t1_count_q <= 16'd0;
			t1_latch_q <= 16'd0;
			t2_count_q <= 16'd0;
			t2_low_q   <= 8'd0;
		end else if (adv_s1) begin
			acr_q      <= acr_d;
			pcr_q      <= pcr_d;
			flags_q    <= flags_d;
			enable_q   <= enable_d;
			sr_q       <= sr_d;
			latch_a_q  <= latch_a_d;
			latch_b_q  <= latch_b_d;
			ddr_a_q    <= ddr_a_d;
			ddr_b_q    <= ddr_b_d;
			t1_count_q <= t1_count_d;
			t1_latch_q <= t1_latch_d;
			t2_count_q <= t2_count_d;
			t2_low_q   <= t2_low_d;
		end
	end

	assign out_valid  = valid_s2;
	assign read_data  = read_data_s2;
	assign irq_bits   = irq_bits_s2;
	assign port_a_out = port_a_out_s2;
	assign port_b_out = port_b_out_s2;
	assign dir_a      = dir_a_s2;
	assign dir_b      = dir_b_s2;

	// ---------------- assertions ----------------
	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("in_ready low with an empty result register");

	// an accepted item is held in the input register next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item lost before the input register");

	// the reported interrupt bits match the stored flags and enables
	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (irq_bits_s2 == (enable_q & flags_q)))
		else $error("irq_bits disagree with flag and enable state");

	// timer 2 does not count in pulse count mode
	a_t2_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd_s1 == CMD_TICK && acr_q[ACR_T2_PULSE]) |=> $stable(t2_count_q))
		else $error("timer 2 moved in pulse count mode");

endmodule
